@@ hw/rtl/swtk_pkg.sv @@
`timescale 1ns / 1ps

package swtk_pkg;

  localparam int DATA_W = 32;
  localparam int REG_W  = 7;
  localparam int IDX_W  = 8;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = 8'd0;
  localparam logic [IDX_W-1:0] REG_TOP_COUNT   = 8'd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
    logic        [DATA_W-1:0] step_tag;
  } swtk_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic        [DATA_W-1:0] result_tag;
    logic                     is_smoothed;
  } swtk_out_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic                     evict;
    logic                     insert;
    logic                     sum;
    logic signed [DATA_W-1:0] sample;
  } swtk_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_INSERT,
    S_SUM,
    S_START,
    S_DIV,
    S_OUT
  } swtk_state_t;

endpackage

@@ hw/rtl/swtk_cell.sv @@
`timescale 1ns / 1ps

module swtk_cell import swtk_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int INDEX      = 0
) (
  input  logic                                           clk,
  input  swtk_ctrl_t                                     ctrl,
  input  logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] evict_pos,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]                fill,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]                topk,
  input  logic signed [DATA_W-1:0]                       left_val,
  input  logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] left_age,
  input  logic                                           left_ge,
  input  logic signed [DATA_W+$clog2(MAX_WINDOW+1):0]    left_psum,
  input  logic signed [DATA_W-1:0]                       right_val,
  input  logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] right_age,
  output logic signed [DATA_W-1:0]                       val,
  output logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] age,
  output logic                                           ge,
  output logic signed [DATA_W+$clog2(MAX_WINDOW+1):0]    psum
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW = DATA_W + $clog2(MAX_WINDOW + 1) + 1;

  logic in_window;
  logic in_top;
  logic signed [SW-1:0] addend;

  // entry holds a live sample and is not below the new one
  assign in_window = 32'(INDEX) < 32'(fill);
  assign ge        = in_window && (val >= ctrl.sample);
  assign in_top    = 32'(INDEX) < 32'(topk);
  assign addend    = in_top ? {{(SW-DATA_W){val[DATA_W-1]}}, val} : '0;

  // evict closes the gap from the right, insert opens one from the left
  always_ff @(posedge clk) begin
    if (ctrl.evict) begin
      if (32'(INDEX) >= 32'(evict_pos)) begin
        val <= right_val;
        age <= right_age;
      end
    end else if (ctrl.insert) begin
      if (ge) begin
        age <= age + AW'(1);
      end else if (left_ge) begin
        val <= ctrl.sample;
        age <= '0;
      end else begin
        val <= left_val;
        age <= left_age + AW'(1);
      end
    end
  end

  // partial sum wave running down the row
  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      psum <= left_psum + addend;
    end
  end

endmodule

@@ hw/rtl/swtk_div.sv @@
`timescale 1ns / 1ps

module swtk_div import swtk_pkg::*; #(
  parameter int SW = 40,
  parameter int CW = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [SW-1:0]     dividend,
  input  logic [CW-1:0]            divisor,
  output logic                     done,
  output logic signed [DATA_W-1:0] quotient
);

  localparam int NW = $clog2(SW + 1);

  logic [SW-1:0] mag;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic          neg;
  logic [NW-1:0] cnt;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem, mag[SW-1]};
  assign fits  = trial >= {1'b0, dvs};

  // restoring divide on the magnitude, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= NW'(SW);
      end else if (cnt != '0) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= dividend[SW-1] ? SW'(-dividend) : dividend;
      neg <= dividend[SW-1];
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? CW'(trial - {1'b0, dvs}) : trial[CW-1:0];
      mag <= {mag[SW-2:0], fits};
    end
  end

  // truncation toward zero
  assign quotient = neg ? -$signed(mag[DATA_W-1:0]) : $signed(mag[DATA_W-1:0]);

endmodule

@@ hw/rtl/sliding_window_top_k_mean.sv @@
`timescale 1ns / 1ps

// Sliding-window top-k mean. One sample transaction is taken at a time and gives
// exactly one result. With the window disabled the raw sample goes straight to the
// output; while the window fills, it is first inserted and then leaves raw. A
// smoothed result is made in steps: an evict (only when the window is full) and an
// insert in the cell row, then the partial sum ripples through all MAX_WINDOW cells
// one cell a cycle, and a bit-serial divider works through the SW bits of the sum
// (SW = 32 + clog2(MAX_WINDOW+1) + 1). A finished result waits in the output
// register while the next sample is taken. Configuration writes are always ready;
// a change of either register empties the window.
module sliding_window_top_k_mean import swtk_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  swtk_in_t         sample,
  output logic             result_valid,
  input  logic             result_ready,
  output swtk_out_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = DATA_W + $clog2(MAX_WINDOW + 1) + 1;

  swtk_state_t state, state_next;

  logic [REG_W-1:0] window_size;
  logic [REG_W-1:0] top_count;
  logic [CW-1:0]    fill, fill_next;
  logic [CW-1:0]    weff;
  logic [CW-1:0]    keff;
  logic [REG_W-1:0] kraw;
  logic [CW-1:0]    sum_cnt, sum_cnt_next;
  logic             raw, raw_next;
  swtk_in_t         item;
  swtk_ctrl_t       ctrl;
  logic [AW-1:0]    evict_pos;
  logic             cfg_clear;
  logic             div_start;
  logic             div_done;
  logic signed [DATA_W-1:0] div_q;
  logic             load_out;
  logic signed [DATA_W-1:0] out_value;

  logic signed [DATA_W-1:0] cell_val [MAX_WINDOW];
  logic [AW-1:0]            cell_age [MAX_WINDOW];
  logic                     cell_ge  [MAX_WINDOW];
  logic signed [SW-1:0]     cell_ps  [MAX_WINDOW];

  assign cfg_ready    = 1'b1;
  assign sample_ready = (state == S_IDLE);

  // effective window and count
  always_comb begin
    weff = (32'(window_size) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(window_size);
    kraw = (top_count == '0) ? REG_W'(1) : top_count;
    keff = (32'(kraw) > 32'(weff)) ? weff : CW'(kraw);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= '0;
      top_count   <= REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WINDOW_SIZE) begin
        window_size <= cfg_data;
      end else if (cfg_index == REG_TOP_COUNT) begin
        top_count <= cfg_data;
      end
    end
  end

  assign cfg_clear = cfg_valid &&
                     (((cfg_index == REG_WINDOW_SIZE) && (cfg_data != window_size)) ||
                      ((cfg_index == REG_TOP_COUNT) && (cfg_data != top_count)));

  // oldest entry has age fill-1
  always_comb begin
    evict_pos = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if ((32'(i) < 32'(fill)) && (32'(cell_age[i]) == 32'(fill) - 1)) begin
        evict_pos = evict_pos | AW'(i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    sum_cnt_next = sum_cnt;
    raw_next     = raw;
    ctrl.evict   = 1'b0;
    ctrl.insert  = 1'b0;
    ctrl.sum     = 1'b0;
    ctrl.sample  = item.sample_value;
    div_start    = 1'b0;
    load_out     = 1'b0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          if (weff == '0) begin
            raw_next   = 1'b1;
            state_next = S_OUT;
          end else if (32'(fill) + 1 < 32'(weff)) begin
            raw_next   = 1'b1;
            state_next = S_INSERT;
          end else if (fill >= weff) begin
            raw_next   = 1'b0;
            state_next = S_EVICT;
          end else begin
            raw_next   = 1'b0;
            state_next = S_INSERT;
          end
        end
      end
      S_EVICT: begin
        ctrl.evict = 1'b1;
        fill_next  = fill - CW'(1);
        state_next = S_INSERT;
      end
      S_INSERT: begin
        ctrl.insert  = 1'b1;
        fill_next    = fill + CW'(1);
        sum_cnt_next = '0;
        state_next   = raw ? S_OUT : S_SUM;
      end
      S_SUM: begin
        ctrl.sum     = 1'b1;
        sum_cnt_next = sum_cnt + CW'(1);
        if (32'(sum_cnt) == MAX_WINDOW - 1) begin
          state_next = S_START;
        end
      end
      S_START: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      sum_cnt <= '0;
      raw     <= 1'b0;
    end else begin
      state   <= state_next;
      sum_cnt <= sum_cnt_next;
      raw     <= raw_next;
      fill    <= cfg_clear ? '0 : fill_next;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      item <= sample;
    end
  end

  // row of cells
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swtk_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .evict_pos (evict_pos),
      .fill      (fill),
      .topk      (keff),
      .left_val  ((i == 0) ? cell_val[0] : cell_val[(i == 0) ? 0 : i-1]),
      .left_age  ((i == 0) ? cell_age[0] : cell_age[(i == 0) ? 0 : i-1]),
      .left_ge   ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i-1]),
      .left_psum ((i == 0) ? SW'(0) : cell_ps[(i == 0) ? 0 : i-1]),
      .right_val (cell_val[(i == MAX_WINDOW-1) ? i : i+1]),
      .right_age (cell_age[(i == MAX_WINDOW-1) ? i : i+1]),
      .val       (cell_val[i]),
      .age       (cell_age[i]),
      .ge        (cell_ge[i]),
      .psum      (cell_ps[i])
    );
  end

  swtk_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cell_ps[MAX_WINDOW-1]),
    .divisor  (keff),
    .done     (div_done),
    .quotient (div_q)
  );

  // output register
  assign out_value = raw ? item.sample_value : div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.result_value <= out_value;
      result.result_tag   <= item.step_tag;
      result.is_smoothed  <= !raw;
    end
  end

  // window never grows past its capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= MAX_WINDOW)
    else $error("fill count beyond capacity");

  // every insert that meets no configuration change adds exactly one entry
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) && !cfg_clear |=> fill == $past(fill) + CW'(1))
    else $error("insert did not grow the window");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside the divide step");

endmodule
